>>> src/pxs_pkg.sv
// Shared types and constants for the nearest-neighbor pixel scaler.
// No dependencies; imported by pixel_replicate_decimate_scaler.
`default_nettype none

package pxs_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;

	localparam int unsigned FACTOR_W = 7;
	localparam int unsigned PAD_W    = 2;
	localparam int unsigned PIX_W    = 24;
	localparam int unsigned RW_W     = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [FACTOR_W-1:0] FACTOR_MAX = 7'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALVE_MODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd2;

	// input beat kinds
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// one result beat; pixel is {red, green, blue}
	typedef struct packed {
		logic [PIX_W-1:0]    pixel;
		logic [FACTOR_W-1:0] copies;
		logic [PAD_W-1:0]    padding;
		logic                row_end;
	} res_t;

endpackage

`default_nettype wire

>>> src/pixel_replicate_decimate_scaler.sv
// A result beat is registered in stage 1, then in the output register, once its input
// beat is accepted, and is held there until it is taken with m_tready.
// Throughput: one input beat (push or tick) per cycle while s_tready is high; a tick
// with nothing pending gives no result. Two result slots (stage 1 and the output
// register) keep input accepted while one finished beat waits. Rate is set by the line
// store's single write port and registered read port. Reset (arst_n, async) clears
// control/config registers but not payload or the line store, which needs no clearing.
`default_nettype none

module pixel_replicate_decimate_scaler
	import pxs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
	input  wire logic                  s_tuser,   // operation
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // blue[7:0], green[15:8], red[23:16],
	                                               // copies[30:24], padding_bytes[32:31], zeros
	output logic                       m_tlast    // row_end
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned EW = (CW + 1 > RW_W) ? CW + 1 : RW_W;
	localparam int unsigned XW = EW + 1;

	// configuration
	logic [FACTOR_W-1:0] scale_factor_q;
	logic                halve_mode_q;
	logic [RW_W-1:0]     row_width_q;

	// scan state
	logic [CW-1:0]       column_count_q, column_count_d;
	logic                row_is_odd_q, row_is_odd_d;
	logic [FACTOR_W-1:0] replays_left_q, replays_left_d;
	logic [CW-1:0]       replay_column_q, replay_column_d;

	// line store
	logic [PIX_W-1:0]    line_store [MAX_WIDTH];

	// pipeline
	logic                valid_s1, valid_s2;
	res_t                res_s1, res_s2, res_d;
	logic                use_mem_s1, use_mem_d;
	logic [PIX_W-1:0]    rd_s1;
	logic                has_res;
	logic                accept, advance;
	logic                mem_we, mem_re;

	// effective settings
	logic [EW-1:0]       rw_ext, w_eff;
	logic                one_col, halve_eff;
	logic [FACTOR_W-1:0] factor_eff, copies_eff;
	logic [XW-1:0]       w_x, col_p1, col_p2, rc_p1, w_p1;
	logic [PAD_W-1:0]    pad_prod;
	logic [PAD_W-1:0]    pad_row;
	logic                last, r_end, keep;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		rw_ext = EW'(row_width_q);
		if (rw_ext == '0) begin
			w_eff = EW'(1);
		end else if (rw_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = rw_ext;
		end
		one_col   = (w_eff == EW'(1));
		halve_eff = halve_mode_q && !one_col;
		if (one_col || scale_factor_q == '0) begin
			factor_eff = FACTOR_W'(1);
		end else if (scale_factor_q > FACTOR_MAX) begin
			factor_eff = FACTOR_MAX;
		end else begin
			factor_eff = scale_factor_q;
		end
		copies_eff = halve_eff ? FACTOR_W'(1) : factor_eff;
		// 3 bytes per pixel: padding is the output pixel count mod 4
		w_x      = XW'(w_eff);
		w_p1     = w_x + XW'(1);
		pad_prod = w_eff[1:0] * factor_eff[1:0];
		pad_row  = halve_eff ? w_p1[2:1] : pad_prod;

		col_p1 = XW'(column_count_q) + XW'(1);
		col_p2 = XW'(column_count_q) + XW'(2);
		rc_p1  = XW'(replay_column_q) + XW'(1);
		last   = (col_p1 >= w_x);
		r_end  = (rc_p1 >= w_x);
		keep   = !row_is_odd_q && !column_count_q[0];
	end

	always_comb begin
		has_res         = 1'b0;
		use_mem_d       = 1'b0;
		mem_we          = 1'b0;
		mem_re          = 1'b0;
		res_d           = '0;
		column_count_d  = column_count_q;
		row_is_odd_d    = row_is_odd_q;
		replays_left_d  = replays_left_q;
		replay_column_d = replay_column_q;
		if (s_tuser == OP_TICK) begin
			if (replays_left_q != '0) begin
				has_res       = 1'b1;
				use_mem_d     = 1'b1;
				mem_re        = 1'b1;
				res_d.copies  = copies_eff;
				res_d.row_end = r_end;
				res_d.padding = r_end ? pad_row : '0;
				if (r_end) begin
					replay_column_d = '0;
					replays_left_d  = replays_left_q - FACTOR_W'(1);
				end else begin
					replay_column_d = replay_column_q + CW'(1);
				end
			end
		end else if (replays_left_q != '0) begin
			// push while a replay is pending: dropped
			has_res = 1'b1;
		end else begin
			has_res = 1'b1;
			if (halve_eff) begin
				if (keep) begin
					res_d.pixel   = s_tdata[PIX_W-1:0];
					res_d.copies  = FACTOR_W'(1);
					res_d.row_end = (col_p2 >= w_x);
					res_d.padding = (col_p2 >= w_x) ? pad_row : '0;
				end
			end else begin
				mem_we        = 1'b1;
				res_d.pixel   = s_tdata[PIX_W-1:0];
				res_d.copies  = factor_eff;
				res_d.row_end = last;
				res_d.padding = last ? pad_row : '0;
				if (last) begin
					replays_left_d  = factor_eff - FACTOR_W'(1);
					replay_column_d = '0;
				end
			end
			if (last) begin
				column_count_d = '0;
				row_is_odd_d   = !row_is_odd_q;
			end else begin
				column_count_d = column_count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q  <= FACTOR_W'(1);
			halve_mode_q    <= 1'b0;
			row_width_q     <= RW_W'(1);
			column_count_q  <= '0;
			row_is_odd_q    <= 1'b0;
			replays_left_q  <= '0;
			replay_column_q <= '0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCALE_FACTOR: scale_factor_q <= cfg_data[FACTOR_W-1:0];
					REG_HALVE_MODE:   halve_mode_q   <= cfg_data[0];
					REG_ROW_WIDTH:    row_width_q    <= cfg_data[RW_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				column_count_q  <= column_count_d;
				row_is_odd_q    <= row_is_odd_d;
				replays_left_q  <= replays_left_d;
				replay_column_q <= replay_column_d;
			end
			if (accept && has_res) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			res_s1     <= res_d;
			use_mem_s1 <= use_mem_d;
		end
		if (advance) begin
			res_s2.pixel   <= use_mem_s1 ? rd_s1 : res_s1.pixel;
			res_s2.copies  <= res_s1.copies;
			res_s2.padding <= res_s1.padding;
			res_s2.row_end <= res_s1.row_end;
		end
	end

	// line store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			line_store[column_count_q] <= s_tdata[PIX_W-1:0];
		end
		if (accept && mem_re) begin
			rd_s1 <= line_store[replay_column_q];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.row_end;
	assign m_tdata  = {
		(OUT_DATA_W - PIX_W - FACTOR_W - PAD_W)'(0),
		res_s2.padding, res_s2.copies, res_s2.pixel
	};

	// replay position only moves while replays are pending
	a_replay_col_idle: assert property (@(posedge clk) disable iff (!arst_n)
		replay_column_q != '0 |-> replays_left_q != '0)
		else $error("replay column nonzero with no replays pending");

	a_replays_bound: assert property (@(posedge clk) disable iff (!arst_n)
		replays_left_q < FACTOR_MAX)
		else $error("replay count above factor limit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with a free result slot");

	a_dropped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.copies == '0 |-> !m_tlast && res_s2.padding == '0)
		else $error("dropped beat marks a row end");

	a_pending_blocks_rows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == OP_PUSH && replays_left_q != '0 |=>
			$stable(column_count_q) && $stable(row_is_odd_q))
		else $error("dropped push changed the column state");

endmodule

`default_nettype wire
